// ===== src/aarm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aarm_pkg: shared types and constants
// Fixed-point constants, CORDIC arctangent table and the front-to-back request.
// ---------------------------------------------------------------------------
package aarm_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [35:0] Q30_ONE     = 36'sd1073741824;
  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0] Q14_ONE     = 16'sd16384;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:    atan_q30 = 32'h3243F6A8;
      5'd1:    atan_q30 = 32'h1DAC6705;
      5'd2:    atan_q30 = 32'h0FADBAFC;
      5'd3:    atan_q30 = 32'h07F56EA6;
      5'd4:    atan_q30 = 32'h03FEAB76;
      5'd5:    atan_q30 = 32'h01FFD55B;
      5'd6:    atan_q30 = 32'h00FFFAAA;
      5'd7:    atan_q30 = 32'h007FFF55;
      5'd8:    atan_q30 = 32'h003FFFEA;
      5'd9:    atan_q30 = 32'h001FFFFD;
      5'd10:   atan_q30 = 32'h000FFFFF;
      5'd11:   atan_q30 = 32'h0007FFFF;
      5'd12:   atan_q30 = 32'h0003FFFF;
      5'd13:   atan_q30 = 32'h0001FFFF;
      5'd14:   atan_q30 = 32'h0000FFFF;
      5'd15:   atan_q30 = 32'h00007FFF;
      5'd16:   atan_q30 = 32'h00003FFF;
      5'd17:   atan_q30 = 32'h00001FFF;
      5'd18:   atan_q30 = 32'h00000FFF;
      5'd19:   atan_q30 = 32'h000007FF;
      5'd20:   atan_q30 = 32'h000003FF;
      5'd21:   atan_q30 = 32'h000001FF;
      5'd22:   atan_q30 = 32'h000000FF;
      5'd23:   atan_q30 = 32'h0000007F;
      default: atan_q30 = 32'h00000000;
    endcase
  endfunction

  // classified request handed from front to back
  typedef struct packed {
    logic               zero;
    logic               neg;
    logic signed [31:0] ang;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } req_t;

endpackage

// ===== src/aarm_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aarm_front: request intake
// Registers the request, folds the angle into -pi/2..pi/2, flags a zero axis.
// ---------------------------------------------------------------------------
module aarm_front import aarm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic signed [15:0] angle,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  output logic               req_valid,
  input  logic               req_ready,
  output req_t               req
);

  logic signed [35:0] a0, a1, a2;
  logic               neg;
  req_t               req_next;

  always_comb begin
    a0  = 36'(angle) <<< 18;
    a1  = a0;
    if (a0 > Q30_PI) a1 = a0 - Q30_TWO_PI;
    else if (a0 < -Q30_PI) a1 = a0 + Q30_TWO_PI;
    a2  = a1;
    neg = 1'b0;
    if (a1 > Q30_HALF_PI) begin
      a2 = a1 - Q30_PI;
      neg = 1'b1;
    end else if (a1 < -Q30_HALF_PI) begin
      a2 = a1 + Q30_PI;
      neg = 1'b1;
    end
    req_next.zero = (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);
    req_next.neg  = neg;
    req_next.ang  = a2[31:0];
    req_next.ax   = axis_x;
    req_next.ay   = axis_y;
    req_next.az   = axis_z;
  end

  assign ready = !req_valid || req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (ready) begin
      req_valid <= valid;
    end
    if (ready && valid) req <= req_next;
  end

endmodule

// ===== src/aarm_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aarm_queue: two-entry request queue
// Decouples intake from the compute pipeline; full throughput with stalls.
// ---------------------------------------------------------------------------
module aarm_queue import aarm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output req_t out_req
);

  req_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_req   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) mem[wr_ptr] <= in_req;
  end

endmodule

// ===== src/aarm_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aarm_back: rotation matrix pipeline
// CORDIC stages and a restoring square root run side by side, then division,
// products, sums and rounding; a stall-all pipeline with valid per stage.
// ---------------------------------------------------------------------------
module aarm_back import aarm_pkg::*; #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               valid,
  input  logic               ready,
  output logic signed [15:0] r0c0,
  output logic signed [15:0] r0c1,
  output logic signed [15:0] r0c2,
  output logic signed [15:0] r1c0,
  output logic signed [15:0] r1c1,
  output logic signed [15:0] r1c2,
  output logic signed [15:0] r2c0,
  output logic signed [15:0] r2c1,
  output logic signed [15:0] r2c2,
  output logic               axis_zero
);

  localparam int NC = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam int SQ = 32;                 // root bits, two radicand bits a stage
  localparam int DV = 31;                 // quotient bits 30..0
  localparam int P1 = (NC > SQ) ? NC : SQ;
  localparam int NS = P1 + DV + 4;        // total stages

  logic          adv;
  logic [NS:1]   vld;
  assign adv = !vld[NS] || ready;
  assign req_ready = adv;
  assign valid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-1:1], req_valid};
    end
  end

  // phase 1: CORDIC and square root in parallel, P1 stages
  logic signed [33:0] cx [P1+1];
  logic signed [33:0] cy [P1+1];
  logic signed [32:0] cz [P1+1];
  logic        [65:0] sv [P1+1];
  logic        [32:0] sr [P1+1];
  logic               pz [P1+1];
  logic               pn [P1+1];
  logic signed [15:0] px [P1+1], py [P1+1], pzz [P1+1];

  always_comb begin
    cx[0]  = CORDIC_GAIN;
    cy[0]  = '0;
    cz[0]  = 33'(req.ang);
    sv[0]  = 66'({(34'(req.ax) * 34'(req.ax)) + (34'(req.ay) * 34'(req.ay))
                  + (34'(req.az) * 34'(req.az))}) << 32;
    sr[0]  = '0;
    pz[0]  = req.zero;
    pn[0]  = req.neg;
    px[0]  = req.ax;
    py[0]  = req.ay;
    pzz[0] = req.az;
  end

  for (genvar g = 0; g < P1; g++) begin : g_p1
    logic signed [33:0] nx, ny;
    logic signed [32:0] nz;
    logic        [65:0] nv;
    logic        [32:0] nr;
    logic        [66:0] trial;
    always_comb begin
      nx = cx[g];
      ny = cy[g];
      nz = cz[g];
      if (g < NC) begin
        if (!cz[g][32]) begin
          nx = cx[g] - (cy[g] >>> g);
          ny = cy[g] + (cx[g] >>> g);
          nz = cz[g] - 33'(atan_q30(5'(g)));
        end else begin
          nx = cx[g] + (cy[g] >>> g);
          ny = cy[g] - (cx[g] >>> g);
          nz = cz[g] + 33'(atan_q30(5'(g)));
        end
      end
      nv = sv[g];
      nr = sr[g];
      trial = '0;
      if (g < SQ) begin
        trial = (67'(sr[g]) << (2 * (SQ - 1 - g) + 2)) + (67'd1 << (2 * (SQ - 1 - g)));
        if (67'(sv[g]) >= trial) begin
          nv = sv[g] - trial[65:0];
          nr = (sr[g] << 1) | 33'd1;
        end else begin
          nr = sr[g] << 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cx[g+1] <= nx;  cy[g+1] <= ny;  cz[g+1] <= nz;
        sv[g+1] <= nv;  sr[g+1] <= nr;
        pz[g+1] <= pz[g]; pn[g+1] <= pn[g];
        px[g+1] <= px[g]; py[g+1] <= py[g]; pzz[g+1] <= pzz[g];
      end
    end
  end

  // phase 2: three restoring dividers, |a|<<46 / r, one quotient bit a stage
  logic        [32:0] dr [DV+1];
  logic        [62:0] rm [DV+1][3];
  logic        [30:0] qt [DV+1][3];
  logic        [15:0] mg [DV+1][3];
  logic               sg [DV+1][3];
  logic signed [34:0] ds [DV+1], dc [DV+1];
  logic               dz [DV+1];

  always_comb begin
    dr[0] = (sr[P1] == 33'd0) ? 33'd1 : sr[P1];
    ds[0] = pn[P1] ? -35'(cy[P1]) : 35'(cy[P1]);
    dc[0] = pn[P1] ? -35'(cx[P1]) : 35'(cx[P1]);
    dz[0] = pz[P1];
    sg[0][0] = px[P1][15];
    sg[0][1] = py[P1][15];
    sg[0][2] = pzz[P1][15];
    mg[0][0] = px[P1][15] ? 16'(-17'(px[P1])) : px[P1];
    mg[0][1] = py[P1][15] ? 16'(-17'(py[P1])) : py[P1];
    mg[0][2] = pzz[P1][15] ? 16'(-17'(pzz[P1])) : pzz[P1];
    for (int k = 0; k < 3; k++) begin
      // stage 0 starts from the shifted magnitude itself
      rm[0][k] = '0;
      qt[0][k] = '0;
    end
  end

  // a quotient of 2^31 or more is clamped: detected via shifted magnitude >= r<<31
  logic ov [DV+1][3];
  always_comb begin
    for (int k = 0; k < 3; k++) ov[0][k] = 1'b0;
  end

  for (genvar g = 0; g < DV; g++) begin : g_dv
    logic [62:0] nrm [3];
    logic [30:0] nq  [3];
    logic        nov [3];
    logic [94:0] num;
    always_comb begin
      num = '0;
      for (int k = 0; k < 3; k++) begin
        nrm[k] = rm[g][k];
        nq[k]  = qt[g][k];
        nov[k] = ov[g][k];
      end
      if (g == 0) begin
        for (int k = 0; k < 3; k++) begin
          num    = 95'({mg[0][k], 46'd0});
          nov[k] = num >= (95'(dr[0]) << 31);
          nrm[k] = nov[k] ? 63'd0 : 63'(num - ((num >= (95'(dr[0]) << 30)) ?
                   (95'(dr[0]) << 30) : 95'd0));
          nq[k]  = 31'((num >= (95'(dr[0]) << 30)) ? 1 : 0) << 30;
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (rm[g][k] >= (63'(dr[g]) << (30 - g))) begin
            nrm[k] = rm[g][k] - (63'(dr[g]) << (30 - g));
            nq[k]  = qt[g][k] | (31'd1 << (30 - g));
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dr[g+1] <= dr[g]; ds[g+1] <= ds[g]; dc[g+1] <= dc[g]; dz[g+1] <= dz[g];
        for (int k = 0; k < 3; k++) begin
          rm[g+1][k] <= nrm[k]; qt[g+1][k] <= nq[k]; ov[g+1][k] <= nov[k];
          mg[g+1][k] <= mg[g][k]; sg[g+1][k] <= sg[g][k];
        end
      end
    end
  end

  // signed unit components
  logic signed [31:0] u [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [30:0] q;
      q = (ov[DV][k] || qt[DV][k] > 31'h40000000) ? 31'h40000000 : qt[DV][k];
      u[k] = sg[DV][k] ? -32'(q) : 32'(q);
    end
  end

  // stage A: pairwise products and u*s
  logic signed [31:0] pp [6];
  logic signed [34:0] us [3];
  logic signed [34:0] sa_t, sa_c;
  logic               sa_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      pp[0] <= 32'((64'(u[0]) * 64'(u[0])) >>> 30);
      pp[1] <= 32'((64'(u[1]) * 64'(u[1])) >>> 30);
      pp[2] <= 32'((64'(u[2]) * 64'(u[2])) >>> 30);
      pp[3] <= 32'((64'(u[0]) * 64'(u[1])) >>> 30);
      pp[4] <= 32'((64'(u[0]) * 64'(u[2])) >>> 30);
      pp[5] <= 32'((64'(u[1]) * 64'(u[2])) >>> 30);
      for (int k = 0; k < 3; k++) us[k] <= 35'((67'(u[k]) * 67'(ds[DV])) >>> 30);
      sa_t <= 35'(Q30_ONE) - dc[DV];
      sa_c <= dc[DV];
      sa_z <= dz[DV];
    end
  end

  // stage B: times t
  logic signed [34:0] pt [6];
  logic signed [34:0] sb_us [3];
  logic signed [34:0] sb_c;
  logic               sb_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) pt[k] <= 35'((67'(pp[k]) * 67'(sa_t)) >>> 30);
      sb_us <= us;
      sb_c  <= sa_c;
      sb_z  <= sa_z;
    end
  end

  // stage C: sums
  logic signed [36:0] sm [9];
  logic               sc_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      sm[0] <= 37'(pt[0]) + 37'(sb_c);
      sm[1] <= 37'(pt[3]) - 37'(sb_us[2]);
      sm[2] <= 37'(pt[4]) + 37'(sb_us[1]);
      sm[3] <= 37'(pt[3]) + 37'(sb_us[2]);
      sm[4] <= 37'(pt[1]) + 37'(sb_c);
      sm[5] <= 37'(pt[5]) - 37'(sb_us[0]);
      sm[6] <= 37'(pt[4]) - 37'(sb_us[1]);
      sm[7] <= 37'(pt[5]) + 37'(sb_us[0]);
      sm[8] <= 37'(pt[2]) + 37'(sb_c);
      sc_z  <= sb_z;
    end
  end

  // stage D: round, saturate, identity on zero axis
  logic signed [15:0] rr [9];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      logic signed [36:0] v;
      v = (sm[k] + 37'sd32768) >>> 16;
      if (v > 37'sd32767) rr[k] = 16'sh7FFF;
      else if (v < -37'sd32768) rr[k] = 16'sh8000;
      else rr[k] = v[15:0];
      if (sc_z) rr[k] = (k % 4 == 0) ? Q14_ONE : 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0c0 <= rr[0]; r0c1 <= rr[1]; r0c2 <= rr[2];
      r1c0 <= rr[3]; r1c1 <= rr[4]; r1c2 <= rr[5];
      r2c0 <= rr[6]; r2c1 <= rr[7]; r2c2 <= rr[8];
      axis_zero <= sc_z;
    end
  end

endmodule

// ===== src/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// Path: intake register, two-entry queue, then the back-end pipeline.
// Throughput: one request per cycle, set by the fully pipelined CORDIC, root and
// divider stages; all stages stall together when the output is held.
// Reset: synchronous rst clears all valid flags; no clearing pass.
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix: axis-angle to 3x3 rotation matrix
// Intake front, two-entry queue and fixed-point Rodrigues pipeline.
// ---------------------------------------------------------------------------
module axis_angle_rotation_matrix import aarm_pkg::*; #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] angle,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] r0c0,
  output logic signed [15:0] r0c1,
  output logic signed [15:0] r0c2,
  output logic signed [15:0] r1c0,
  output logic signed [15:0] r1c1,
  output logic signed [15:0] r1c2,
  output logic signed [15:0] r2c0,
  output logic signed [15:0] r2c1,
  output logic signed [15:0] r2c2,
  output logic               axis_zero
);

  logic f_valid, f_ready, q_valid, q_ready;
  req_t f_req, q_req;

  aarm_front u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready),
    .angle, .axis_x, .axis_y, .axis_z,
    .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
  );

  aarm_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_req(f_req),
    .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
  );

  aarm_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
    .clk, .rst, .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .valid(out_valid), .ready(out_ready),
    .r0c0, .r0c1, .r0c2, .r1c0, .r1c1, .r1c2, .r2c0, .r2c1, .r2c2, .axis_zero
  );

`ifndef NO_ASSERTIONS
  a_zero_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && axis_zero |-> r0c0 == Q14_ONE && r0c1 == 16'sd0 && r1c1 == Q14_ONE)
    else $error("zero axis did not give identity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(r0c0) && $stable(r2c2))
    else $error("stalled result changed");
  a_front_stall: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid && $stable(f_req))
    else $error("front request lost under queue stall");
`endif

endmodule

// ===== test/axis_angle_rotation_matrix_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix_tb: self-checking bench for the rotation block
// Drives angle/axis requests with random gaps and checks every matrix entry
// and the zero-axis flag against a fixed-point Rodrigues predictor.
// Also covers long receiver hold-off.
// ---------------------------------------------------------------------------
module axis_angle_rotation_matrix_tb import aarm_pkg::*; ();

  localparam int ITERS    = 16;
  localparam int WD_LIMIT = 5000;
  localparam int HOLD_LEN = 400;

  typedef struct {
    logic signed [15:0] m [9];
    logic               zero;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] angle = '0, axis_x = '0, axis_y = '0, axis_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2;
  logic axis_zero;

  matrix_t expected_q[$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      no_idle = 0;
  bit      hold_req = 0;

  longint atan_tab [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  axis_angle_rotation_matrix #(.TRIG_ITERATIONS(ITERS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_of(longint a, longint unsigned r);
    longint unsigned q;
    q = (longint'(a < 0 ? -a : a) << 46) / r;
    if (q > 64'd1073741824) q = 64'd1073741824;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic matrix_t rotation_of(logic signed [15:0] ang_in,
      logic signed [15:0] x_in, logic signed [15:0] y_in, logic signed [15:0] z_in);
    matrix_t res;
    longint ax, ay, az, a, x, y, z, dx, dy, s, c, t, ux, uy, uz;
    longint xx, yy, zz, xy, xz, yz;
    longint unsigned n2, r;
    bit neg;
    ax = x_in; ay = y_in; az = z_in;
    n2 = ax * ax + ay * ay + az * az;
    if (n2 == 0) begin
      foreach (res.m[k]) res.m[k] = (k % 4 == 0) ? 16'sd16384 : 16'sd0;
      res.zero = 1'b1;
      return res;
    end
    r  = root64(n2 << 32);
    ux = unit_of(ax, r);
    uy = unit_of(ay, r);
    uz = unit_of(az, r);
    a = longint'(ang_in) * 262144;
    neg = 0;
    if (a > longint'(Q30_PI)) a -= longint'(Q30_TWO_PI);
    else if (a < -longint'(Q30_PI)) a += longint'(Q30_TWO_PI);
    if (a > longint'(Q30_HALF_PI)) begin
      a -= longint'(Q30_PI); neg = 1;
    end else if (a < -longint'(Q30_HALF_PI)) begin
      a += longint'(Q30_PI); neg = 1;
    end
    x = longint'(CORDIC_GAIN); y = 0; z = a;
    for (int i = 0; i < ITERS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    t = 64'd1073741824 - c;
    xx = fmul(fmul(ux, ux), t);
    yy = fmul(fmul(uy, uy), t);
    zz = fmul(fmul(uz, uz), t);
    xy = fmul(fmul(ux, uy), t);
    xz = fmul(fmul(ux, uz), t);
    yz = fmul(fmul(uy, uz), t);
    res.m[0] = to_q14(xx + c);
    res.m[1] = to_q14(xy - fmul(uz, s));
    res.m[2] = to_q14(xz + fmul(uy, s));
    res.m[3] = to_q14(xy + fmul(uz, s));
    res.m[4] = to_q14(yy + c);
    res.m[5] = to_q14(yz - fmul(ux, s));
    res.m[6] = to_q14(xz - fmul(uy, s));
    res.m[7] = to_q14(yz + fmul(ux, s));
    res.m[8] = to_q14(zz + c);
    res.zero = 1'b0;
    return res;
  endfunction

  function automatic int gap_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // one request; valid stays up when the next follows with no gap
  task automatic send_request(logic signed [15:0] a, logic signed [15:0] x,
      logic signed [15:0] y, logic signed [15:0] z);
    int g;
    @(negedge clk);
    in_valid = 1'b1;
    angle = a; axis_x = x; axis_y = y; axis_z = z;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(rotation_of(a, x, y, z));
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  initial begin : receiver
    int gap_left = 0, hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready = 1'b0;
        gap_left--;
      end else begin
        out_ready = 1'b1;
        gap_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    matrix_t want;
    logic signed [15:0] got [9];
    got = '{r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2};
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_q.pop_front();
        foreach (got[k])
          if (got[k] !== want.m[k])
            report_mismatch($sformatf("r%0dc%0d", k / 3, k % 3), got[k], want.m[k]);
        if (axis_zero !== want.zero)
          report_mismatch("axis_zero", axis_zero, want.zero);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no progress");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_extremes();
    logic signed [15:0] ext [5] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'shFFFF};
    foreach (ext[i]) send_request(ext[i], 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(16'sd12868, 16'sd16384, 16'sd0, 16'sd0);
    send_request(-16'sd12868, 16'sd0, 16'sd16384, 16'sd0);
    send_request(16'sd6434, 16'sd0, 16'sd0, 16'sd16384);
    send_request(-16'sd6434, 16'sd0, 16'sd0, -16'sd16384);
    send_request(16'sd6435, 16'sd1, 16'sd0, 16'sd0);
    send_request(16'sd12869, 16'sh8000, 16'sh7FFF, 16'sd1);
    send_request(16'sd25736, 16'shFFFF, 16'sd0, 16'sh7FFF);
    send_request(-16'sd25736, 16'sd9459, 16'sd9459, 16'sd9459);
  endtask

  task automatic test_zero_axis();
    send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sd4000, 16'sd0, 16'sd0, 16'sd1);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32)) - 16);
      2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($urandom_range(0, 1) ? 0 : $urandom);
    endcase
  endfunction

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 300 == 0) no_idle = !no_idle;
      if ($urandom_range(0, 24) == 0) send_request(16'($urandom), 16'sd0, 16'sd0, 16'sd0);
      else send_request(16'($urandom), rand_comp(), rand_comp(), rand_comp());
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    bit keep = no_idle;
    no_idle = 1;
    hold_req = 1;
    for (int n = 0; n < 150; n++)
      send_request(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    no_idle = keep;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_zero_axis();
    test_backpressure();
    test_random(1050);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
